// ===== hdl/timestamp_string_parser_core_macros.svh =====
// assertion macros for the timestamp string parser
// expects clk and rst_n in the scope of the module that uses them
`ifndef TIMESTAMP_STRING_PARSER_CORE_MACROS_SVH
`define TIMESTAMP_STRING_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tsp_pkg.sv =====
// package for the timestamp string parser: field widths, codes and characters
// no dependencies
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned PACKED_W = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned DIGIT_W  = 4;

  localparam logic [CHAR_W-1:0] CHR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_NINE = 8'h39;

  localparam logic [YEAR_W-1:0]   YEAR_MAX   = '1;
  localparam logic [MONTH_W-1:0]  MONTH_MAX  = '1;
  localparam logic [DAY_W-1:0]    DAY_MAX    = '1;
  localparam logic [HOUR_W-1:0]   HOUR_MAX   = '1;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = '1;

  localparam logic UPPER_MODE_RST = 1'b0;

  typedef enum logic [2:0] {
    FLD_YEAR,
    FLD_MONTH,
    FLD_DAY,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_DONE
  } field_t;

endpackage

// ===== hdl/timestamp_string_parser_core.sv =====
// timestamp string parser: one string byte per beat in, one packed timestamp per string out
// depends on tsp_pkg and timestamp_string_parser_core_macros.svh
// result path: a final byte accepted into the input register raises out_valid from the result register
// throughput: one byte per cycle, held back only while a finished result waits
// at the output register and the byte in the input register is a final byte
// reset: synchronous active-low rst_n clears parse state, upper_mode and both valid flags
`timescale 1ns / 1ps

module timestamp_string_parser_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_upper_mode,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tsp_pkg::CHAR_W-1:0]   in_char_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tsp_pkg::PACKED_W-1:0] out_packed_time
);

  import tsp_pkg::*;

  logic                  upper_mode_r;
  logic                  in_vld_r;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r;
  logic                  out_vld_r;
  logic [PACKED_W-1:0]   packed_r;

  logic [YEAR_W-1:0]     year_acc_r,   year_acc_nxt;
  logic [MONTH_W-1:0]    month_acc_r,  month_acc_nxt;
  logic [DAY_W-1:0]      day_acc_r,    day_acc_nxt;
  logic [HOUR_W-1:0]     hour_acc_r,   hour_acc_nxt;
  logic [MINUTE_W-1:0]   minute_acc_r, minute_acc_nxt;
  field_t                field_idx_r,  field_idx_nxt;

  logic                  proceed;
  logic                  is_digit;
  logic [DIGIT_W-1:0]    digit;
  logic [PACKED_W-1:0]   packed_nxt;

  assign cfg_ready       = 1'b1;
  assign proceed         = in_vld_r && (!last_r || !out_vld_r || out_ready);
  assign in_ready        = !in_vld_r || proceed;
  assign out_valid       = out_vld_r;
  assign out_packed_time = packed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_mode_r <= UPPER_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      upper_mode_r <= cfg_upper_mode;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_byte;
      last_r <= in_last_byte;
    end
  end

  // field accumulation and packing
  always_comb begin
    is_digit       = char_r inside {[CHR_ZERO:CHR_NINE]};
    digit          = DIGIT_W'(char_r - CHR_ZERO);
    year_acc_nxt   = year_acc_r;
    month_acc_nxt  = month_acc_r;
    day_acc_nxt    = day_acc_r;
    hour_acc_nxt   = hour_acc_r;
    minute_acc_nxt = minute_acc_r;
    field_idx_nxt  = field_idx_r;
    if (field_idx_r != FLD_DONE && !is_digit) begin
      field_idx_nxt = field_t'(field_idx_r + 3'd1);
    end else if (is_digit) begin
      case (field_idx_r)
        FLD_YEAR: begin
          year_acc_nxt = YEAR_W'(year_acc_r * YEAR_W'(10) + YEAR_W'(digit));
        end
        FLD_MONTH: begin
          month_acc_nxt = MONTH_W'(month_acc_r * MONTH_W'(10) + MONTH_W'(digit));
        end
        FLD_DAY: begin
          day_acc_nxt = DAY_W'(day_acc_r * DAY_W'(10) + DAY_W'(digit));
        end
        FLD_HOUR: begin
          hour_acc_nxt = HOUR_W'(hour_acc_r * HOUR_W'(10) + HOUR_W'(digit));
        end
        FLD_MINUTE: begin
          minute_acc_nxt = MINUTE_W'(minute_acc_r * MINUTE_W'(10) + MINUTE_W'(digit));
        end
        default: begin
        end
      endcase
    end
    packed_nxt = {
      (upper_mode_r && field_idx_nxt < FLD_YEAR)   ? YEAR_MAX   : year_acc_nxt,
      (upper_mode_r && field_idx_nxt < FLD_MONTH)  ? MONTH_MAX  : month_acc_nxt,
      (upper_mode_r && field_idx_nxt < FLD_DAY)    ? DAY_MAX    : day_acc_nxt,
      (upper_mode_r && field_idx_nxt < FLD_HOUR)   ? HOUR_MAX   : hour_acc_nxt,
      (upper_mode_r && field_idx_nxt < FLD_MINUTE) ? MINUTE_MAX : minute_acc_nxt
    };
  end

  // parse state, cleared at string end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_acc_r   <= '0;
      month_acc_r  <= '0;
      day_acc_r    <= '0;
      hour_acc_r   <= '0;
      minute_acc_r <= '0;
      field_idx_r  <= FLD_YEAR;
    end else if (proceed) begin
      if (last_r) begin
        year_acc_r   <= '0;
        month_acc_r  <= '0;
        day_acc_r    <= '0;
        hour_acc_r   <= '0;
        minute_acc_r <= '0;
        field_idx_r  <= FLD_YEAR;
      end else begin
        year_acc_r   <= year_acc_nxt;
        month_acc_r  <= month_acc_nxt;
        day_acc_r    <= day_acc_nxt;
        hour_acc_r   <= hour_acc_nxt;
        minute_acc_r <= minute_acc_nxt;
        field_idx_r  <= field_idx_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proceed && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && last_r) begin
      packed_r <= packed_nxt;
    end
  end

  `include "timestamp_string_parser_core_macros.svh"

  `TSP_ASSERT_NEXT(a_clear_after_last, proceed && last_r, field_idx_r == FLD_YEAR && year_acc_r == '0 && minute_acc_r == '0, "parse state not cleared after final beat")
  `TSP_ASSERT_NEXT(a_result_only_from_last, !out_vld_r && !(in_vld_r && last_r), !out_vld_r, "result raised without a final beat")
  `TSP_ASSERT_NEXT(a_done_holds_accs, proceed && !last_r && field_idx_r == FLD_DONE, field_idx_r == FLD_DONE && $stable(year_acc_r) && $stable(minute_acc_r), "accumulators moved after all fields closed")

endmodule

// ===== tb/tb_timestamp_string_parser_core.sv =====
// self-checking bench for timestamp_string_parser_core: drives date-time strings byte by byte
// and checks every stamp against an in-bench parser or the table; depends on tsp_pkg and the core
`timescale 1ns / 1ps

module tb_timestamp_string_parser_core;
  import tsp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_BYTES = 350;
  localparam int unsigned DIR_ROWS = 24;

  typedef struct {
    logic                mode;
    logic [CHAR_W-1:0]   ch;
    logic                last;
    bit                  typed;
    logic [PACKED_W-1:0] stamp;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_upper_mode = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   in_char_byte = '0;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PACKED_W-1:0] out_packed_time;

  // parser shadow state
  logic                upper;
  logic [YEAR_W-1:0]   year_sum;
  logic [MONTH_W-1:0]  month_sum;
  logic [DAY_W-1:0]    day_sum;
  logic [HOUR_W-1:0]   hour_sum;
  logic [MINUTE_W-1:0] minute_sum;
  field_t              cur_field;

  logic [PACKED_W-1:0] pending_stamps[$];
  bit                  steady = 1'b0;
  int unsigned         fails = 0;
  int unsigned         bytes_sent = 0;
  int unsigned         strings_sent = 0;
  int unsigned         stamps_seen = 0;
  int unsigned         mode_writes = 0;
  int unsigned         idle_run = 0;

  dir_row_t dir_rows[DIR_ROWS] = '{
    '{1'b0, "9",   1'b1, 1'b1, 32'h0090_0000},
    '{1'b0, 8'hff, 1'b1, 1'b1, 32'h0000_0000},
    '{1'b0, "1",   1'b0, 1'b0, 32'h0},
    '{1'b0, ":",   1'b0, 1'b0, 32'h0},
    '{1'b0, "2",   1'b0, 1'b0, 32'h0},
    '{1'b0, ":",   1'b0, 1'b0, 32'h0},
    '{1'b0, "3",   1'b0, 1'b0, 32'h0},
    '{1'b0, ":",   1'b0, 1'b0, 32'h0},
    '{1'b0, "4",   1'b0, 1'b0, 32'h0},
    '{1'b0, ":",   1'b0, 1'b0, 32'h0},
    '{1'b0, "5",   1'b1, 1'b1, 32'h0012_1905},
    '{1'b1, "-",   1'b1, 1'b1, 32'h0000_ffff},
    '{1'b1, "7",   1'b1, 1'b1, 32'h007f_ffff},
    '{1'b1, "9",   1'b0, 1'b0, 32'h0},
    '{1'b1, "9",   1'b0, 1'b0, 32'h0},
    '{1'b1, "9",   1'b0, 1'b0, 32'h0},
    '{1'b1, "9",   1'b0, 1'b0, 32'h0},
    '{1'b1, "9",   1'b0, 1'b0, 32'h0},
    '{1'b1, 8'h00, 1'b0, 1'b0, 32'h0},
    '{1'b1, 8'h2f, 1'b0, 1'b0, 32'h0},
    '{1'b1, 8'h3a, 1'b0, 1'b0, 32'h0},
    '{1'b1, 8'hff, 1'b0, 1'b0, 32'h0},
    '{1'b1, 8'h2d, 1'b0, 1'b0, 32'h0},
    '{1'b1, "5",   1'b1, 1'b0, 32'h0}
  };

  timestamp_string_parser_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_upper_mode  (cfg_upper_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_byte    (in_char_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_time (out_packed_time)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void clear_fields();
    year_sum = '0;
    month_sum = '0;
    day_sum = '0;
    hour_sum = '0;
    minute_sum = '0;
    cur_field = FLD_YEAR;
  endfunction

  // returns 1 when the byte closes a string, with the packed timestamp in stamp
  function automatic bit parse_char(input logic [CHAR_W-1:0] ch, input logic last,
                                    output logic [PACKED_W-1:0] stamp);
    logic [DIGIT_W-1:0] dig;
    dig = DIGIT_W'(ch - CHR_ZERO);
    stamp = '0;
    if (cur_field != FLD_DONE) begin
      if (ch >= CHR_ZERO && ch <= CHR_NINE) begin
        case (cur_field)
          FLD_YEAR:  year_sum = year_sum * 10 + dig;
          FLD_MONTH: month_sum = month_sum * 10 + dig;
          FLD_DAY:   day_sum = day_sum * 10 + dig;
          FLD_HOUR:  hour_sum = hour_sum * 10 + dig;
          default:   minute_sum = minute_sum * 10 + dig;
        endcase
      end else begin
        cur_field = field_t'(cur_field + 1);
      end
    end
    if (!last) return 1'b0;
    stamp = {year_sum,
             (upper && cur_field < FLD_MONTH)  ? MONTH_MAX  : month_sum,
             (upper && cur_field < FLD_DAY)    ? DAY_MAX    : day_sum,
             (upper && cur_field < FLD_HOUR)   ? HOUR_MAX   : hour_sum,
             (upper && cur_field < FLD_MINUTE) ? MINUTE_MAX : minute_sum};
    clear_fields();
    return 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] any_separator();
    logic [CHAR_W-1:0] v;
    v = CHAR_W'($urandom_range(255));
    while (v >= CHR_ZERO && v <= CHR_NINE) v = CHAR_W'($urandom_range(255));
    return v;
  endfunction

  // all tasks below start and end at a falling edge
  task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic last,
                           input bit typed, input logic [PACKED_W-1:0] typed_stamp);
    logic [PACKED_W-1:0] stamp;
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= ch;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (parse_char(ch, last, stamp)) pending_stamps.push_back(typed ? typed_stamp : stamp);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results(input int unsigned settle);
    in_valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_upper_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    upper = mode;
    mode_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_string(ref logic [CHAR_W-1:0] s[$]);
    int unsigned nf;
    int unsigned nd;
    s.delete();
    if ($urandom_range(99) < 15) begin
      // noise: raw bytes of any value
      repeat ($urandom_range(1, 12)) s.push_back(CHAR_W'($urandom_range(255)));
    end else begin
      nf = $urandom_range(1, 5);
      for (int unsigned f = 0; f < nf; f++) begin
        nd = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        repeat (nd) s.push_back(CHR_ZERO + CHAR_W'($urandom_range(9)));
        if (f + 1 < nf) s.push_back(any_separator());
      end
      if (nf == 5 && $urandom_range(1) == 1) begin
        s.push_back(any_separator());
        repeat ($urandom_range(0, 4)) s.push_back(CHAR_W'($urandom_range(255)));
      end
      if (s.size() == 0) s.push_back(any_separator());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      stamps_seen++;
      if (pending_stamps.size() == 0) begin
        $display("%0t: unexpected packed_time %08h, expected none", $time, out_packed_time);
        fails++;
      end else begin
        if (out_packed_time !== pending_stamps[0]) begin
          $display("%0t: packed_time expected %08h, actual %08h", $time, pending_stamps[0],
                   out_packed_time);
          fails++;
        end
        void'(pending_stamps.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 13);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("tb_timestamp_string_parser_core failed");
      $finish;
    end
  end

  initial begin
    logic [CHAR_W-1:0] str[$];
    int unsigned target;
    int unsigned phase_strings;
    upper = UPPER_MODE_RST;
    clear_fields();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_mode(1'b0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != upper) begin
        wait_results(SETTLE_CYCLES);
        write_mode(dir_rows[i].mode);
      end
      send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].stamp);
      if (dir_rows[i].last) strings_sent++;
    end
    wait_results(SETTLE_CYCLES);

    for (int unsigned ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] ? 1'b0 : 1'b1);
      steady = (ph == 2);
      target = bytes_sent + PHASE_BYTES;
      phase_strings = 0;
      while (bytes_sent < target) begin
        build_string(str);
        foreach (str[k]) send_byte(str[k], k == str.size() - 1, 1'b0, '0);
        strings_sent++;
        phase_strings++;
        // sender holds off until the output side has caught up
        if (ph == 1 && phase_strings == 20) wait_results(0);
      end
      steady = 1'b0;
      wait_results(SETTLE_CYCLES);
    end

    $display("sent %0d bytes in %0d strings over %0d mode writes, checked %0d timestamps",
             bytes_sent, strings_sent, mode_writes, stamps_seen);
    if (fails == 0) begin
      $display("tb_timestamp_string_parser_core passed");
    end else begin
      $display("tb_timestamp_string_parser_core failed");
    end
    $finish;
  end

endmodule

// ===== timestamp_string_parser_core.f =====
+incdir+hdl
hdl/tsp_pkg.sv
hdl/timestamp_string_parser_core.sv
tb/tb_timestamp_string_parser_core.sv
